/* sv/swmf_pkg.sv */
// ---------------------------------------------------------------------------
// swmf_pkg
// Shared types and constants of the square window median filter.
// ---------------------------------------------------------------------------
package swmf_pkg;

   localparam int FIELD_BITS = 16;
   localparam int CSR_DATA_BITS = 11;
   localparam int CSR_INDEX_BITS = 2;
   localparam int FIFO_DEPTH = 8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RADIUS = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] filtered;
      logic                  frame_end;
      logic [FIELD_BITS-1:0] frame_peak;
   } result_type;

endpackage

/* sv/swmf_ram.sv */
// ---------------------------------------------------------------------------
// swmf_ram
// Simple dual port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
module swmf_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* sv/square_window_median_filter.sv */
// ---------------------------------------------------------------------------
// square_window_median_filter
// Streaming median over a clamp-to-edge square window, with frame peak.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    pixel
//   rsp      out        rsp_valid/stall    filtered, frame_end, frame_peak
//   csr      in         csr_valid/ready    index, data
//
// One pixel per cycle sustained while req is not stalled; a result passes the
// line store read, window shift and median registers, then the result queue.
// A result trails its pixel by r*W+r requests, so the first r*W+r requests
// after reset or a radius, width or height write give no result.
// Reset is synchronous; a radius, width or height write restarts the stream.
// An eight entry result queue absorbs rsp stalls; req stalls once it may fill.
// ---------------------------------------------------------------------------
module square_window_median_filter #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_RADIUS = 1,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [swmf_pkg::FIELD_BITS-1:0]          req_pixel,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [swmf_pkg::FIELD_BITS-1:0]          rsp_filtered,
   output logic                                     rsp_frame_end,
   output logic [swmf_pkg::FIELD_BITS-1:0]          rsp_frame_peak,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [swmf_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [swmf_pkg::CSR_DATA_BITS-1:0]       csr_data
);

   localparam int R = MAX_RADIUS;
   localparam int SIDE = 2 * R + 1;
   localparam int CELLS = SIDE * SIDE;
   localparam int NLINES = 2 * R;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
   localparam int RAD_W = $clog2(R + 1);
   localparam int DIST_W = $clog2(SIDE);
   localparam int FILL_W = $clog2(R * MAX_WIDTH + R + 1);
   localparam int RANK_W = $clog2(CELLS + 1);
   localparam int FD = swmf_pkg::FIFO_DEPTH;
   localparam int PTR_W = $clog2(FD);
   localparam int CNT_W = $clog2(FD + 4);

   typedef struct packed {
      logic             frame_end;
      logic [RAD_W-1:0] left;
      logic [RAD_W-1:0] right;
      logic [RAD_W-1:0] up;
      logic [RAD_W-1:0] down;
   } pos_type;

   // configuration
   logic [RAD_W-1:0] radius_ff;
   logic [WID_W-1:0] width_ff;
   logic [HGT_W-1:0] height_ff;
   logic [RAD_W-1:0] radius_in;
   logic [WID_W-1:0] width_in;
   logic [HGT_W-1:0] height_in;
   logic             restart;

   // stream position
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [FILL_W-1:0] lag;
   logic              produce;
   logic              accept;
   pos_type           pos;

   // stage 1
   logic                  s1_valid_ff;
   logic                  s1_out_ff;
   logic                  s1_byp_ff;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic [COL_W-1:0]      s1_col_ff;
   pos_type               s1_pos_ff;
   logic [PIXEL_BITS-1:0] line_rd [NLINES];
   logic [PIXEL_BITS-1:0] vec [SIDE];
   logic [PIXEL_BITS-1:0] last_vec_ff [NLINES];
   logic [PIXEL_BITS-1:0] cols_ff [SIDE][SIDE];

   // stage 2
   logic                  s2_valid_ff;
   pos_type               s2_pos_ff;
   logic [DIST_W-1:0]     dv [SIDE];
   logic [DIST_W-1:0]     dh [SIDE];
   logic                  av [SIDE];
   logic                  ah [SIDE];
   logic [PIXEL_BITS-1:0] win [CELLS];
   logic                  act [CELLS];
   logic [RANK_W-1:0]     rank [CELLS];
   logic [RANK_W-1:0]     half;
   logic [PIXEL_BITS-1:0] med;

   // stage 3 and result queue
   logic                  s3_valid_ff;
   logic                  s3_end_ff;
   logic [PIXEL_BITS-1:0] s3_med_ff;
   logic [PIXEL_BITS-1:0] peak_ff, peak_in;
   logic [PIXEL_BITS-1:0] new_peak;
   swmf_pkg::result_type  fifo_ff [FD];
   swmf_pkg::result_type  push_data;
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff, busy;
   logic                  pop;

   genvar k;

   // register writes
   always_comb begin
      radius_in = radius_ff;
      width_in = width_ff;
      height_in = height_ff;
      restart = 1'b0;
      if (csr_valid) begin
         unique case (swmf_pkg::csr_index_type'(csr_index))
            swmf_pkg::CSR_RADIUS: begin
               restart = 1'b1;
               if (csr_data[1:0] == 2'd0) begin
                  radius_in = RAD_W'(1);
               end else if (32'(csr_data[1:0]) > R) begin
                  radius_in = RAD_W'(R);
               end else begin
                  radius_in = RAD_W'(csr_data[1:0]);
               end
            end
            swmf_pkg::CSR_WIDTH: begin
               restart = 1'b1;
               if (csr_data == '0) begin
                  width_in = WID_W'(1);
               end else if (32'(csr_data) > MAX_WIDTH) begin
                  width_in = WID_W'(MAX_WIDTH);
               end else begin
                  width_in = WID_W'(csr_data);
               end
            end
            swmf_pkg::CSR_HEIGHT: begin
               restart = 1'b1;
               if (csr_data == '0) begin
                  height_in = HGT_W'(1);
               end else if (32'(csr_data) > MAX_HEIGHT) begin
                  height_in = HGT_W'(MAX_HEIGHT);
               end else begin
                  height_in = HGT_W'(csr_data);
               end
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // flow control
   assign busy = count_ff + CNT_W'(s1_valid_ff) + CNT_W'(s2_valid_ff) + CNT_W'(s3_valid_ff);
   assign req_stall = busy >= CNT_W'(FD);
   assign accept = req_valid & ~req_stall;
   assign rsp_valid = count_ff != '0;
   assign pop = rsp_valid & ~rsp_stall;

   // positions and window rooms
   always_comb begin
      logic [WID_W-1:0] col_rem;
      logic [HGT_W-1:0] row_rem;
      lag = FILL_W'(radius_ff) * FILL_W'(width_ff) + FILL_W'(radius_ff);
      produce = fill_ff >= lag;
      fill_in = produce ? fill_ff : fill_ff + 1'b1;
      in_col_in = (WID_W'(in_col_ff) + 1'b1 >= width_ff) ? '0 : in_col_ff + 1'b1;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (produce) begin
         if (WID_W'(out_col_ff) + 1'b1 >= width_ff) begin
            out_col_in = '0;
            out_row_in = (HGT_W'(out_row_ff) + 1'b1 >= height_ff) ? '0 : out_row_ff + 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end
      col_rem = width_ff - 1'b1 - WID_W'(out_col_ff);
      row_rem = height_ff - 1'b1 - HGT_W'(out_row_ff);
      pos.frame_end = (col_rem == '0) && (row_rem == '0);
      pos.left = (32'(out_col_ff) > R) ? RAD_W'(R) : RAD_W'(out_col_ff);
      pos.right = (32'(col_rem) > R) ? RAD_W'(R) : RAD_W'(col_rem);
      pos.up = (32'(out_row_ff) > R) ? RAD_W'(R) : RAD_W'(out_row_ff);
      pos.down = (32'(row_rem) > R) ? RAD_W'(R) : RAD_W'(row_rem);
   end

   // line stores, one row delay each
   assign vec[0] = s1_pixel_ff;
   generate
      for (k = 0; k < NLINES; k++) begin : g_line
         swmf_ram #(
            .DATA_W(PIXEL_BITS),
            .DEPTH(MAX_WIDTH)
         ) u_line (
            .clock(clock),
            .wr_en(s1_valid_ff),
            .wr_addr(s1_col_ff),
            .wr_data(vec[k]),
            .rd_addr(in_col_ff),
            .rd_data(line_rd[k])
         );
         assign vec[k + 1] = s1_byp_ff ? last_vec_ff[k] : line_rd[k];
      end
   endgenerate

   // window selection and median
   always_comb begin
      logic [DIST_W-1:0] d;
      logic [DIST_W-1:0] m;
      logic [DIST_W-1:0] r;
      r = DIST_W'(radius_ff);
      for (int i = 0; i < SIDE; i++) begin
         if (i >= R) begin
            d = DIST_W'(i - R);
            m = (d < DIST_W'(s2_pos_ff.down)) ? d : DIST_W'(s2_pos_ff.down);
            av[i] = d <= r;
            dv[i] = av[i] ? r - m : '0;
            m = (d < DIST_W'(s2_pos_ff.right)) ? d : DIST_W'(s2_pos_ff.right);
            ah[i] = d <= r;
            dh[i] = ah[i] ? r - m : '0;
         end else begin
            d = DIST_W'(R - i);
            m = (d < DIST_W'(s2_pos_ff.up)) ? d : DIST_W'(s2_pos_ff.up);
            av[i] = d <= r;
            dv[i] = av[i] ? r + m : '0;
            m = (d < DIST_W'(s2_pos_ff.left)) ? d : DIST_W'(s2_pos_ff.left);
            ah[i] = d <= r;
            dh[i] = ah[i] ? r + m : '0;
         end
      end
      for (int i = 0; i < SIDE; i++) begin
         for (int j = 0; j < SIDE; j++) begin
            win[i * SIDE + j] = cols_ff[dh[j]][dv[i]];
            act[i * SIDE + j] = av[i] & ah[j];
         end
      end
      for (int i = 0; i < CELLS; i++) begin
         rank[i] = '0;
         for (int j = 0; j < CELLS; j++) begin
            if (act[j] && ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i)))) begin
               rank[i] = rank[i] + 1'b1;
            end
         end
      end
      half = (RANK_W'(radius_ff) * (RANK_W'(radius_ff) + 1'b1)) << 1;
      med = '0;
      for (int i = 0; i < CELLS; i++) begin
         if (act[i] && (rank[i] == half)) begin
            med = med | win[i];
         end
      end
   end

   // frame peak
   always_comb begin
      new_peak = (s3_med_ff > peak_ff) ? s3_med_ff : peak_ff;
      peak_in = peak_ff;
      if (s3_valid_ff) begin
         peak_in = s3_end_ff ? '0 : new_peak;
      end
      push_data.filtered = swmf_pkg::FIELD_BITS'(s3_med_ff);
      push_data.frame_end = s3_end_ff;
      push_data.frame_peak = s3_end_ff ? swmf_pkg::FIELD_BITS'(new_peak) : '0;
   end

   assign rsp_filtered = fifo_ff[rd_ptr_ff].filtered;
   assign rsp_frame_end = fifo_ff[rd_ptr_ff].frame_end;
   assign rsp_frame_peak = fifo_ff[rd_ptr_ff].frame_peak;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RAD_W'(1);
         width_ff <= WID_W'(MAX_WIDTH);
         height_ff <= HGT_W'(MAX_HEIGHT);
         in_col_ff <= '0;
         fill_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         peak_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else if (restart) begin
         radius_ff <= radius_in;
         width_ff <= width_in;
         height_ff <= height_in;
         in_col_ff <= '0;
         fill_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         peak_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            in_col_ff <= in_col_in;
            fill_ff <= fill_in;
            out_col_ff <= out_col_in;
            out_row_ff <= out_row_in;
         end
         peak_ff <= peak_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff & s1_out_ff;
         s3_valid_ff <= s2_valid_ff;
         if (s3_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(s3_valid_ff) - CNT_W'(pop);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel[PIXEL_BITS-1:0];
         s1_col_ff <= in_col_ff;
         s1_out_ff <= produce;
         s1_byp_ff <= s1_valid_ff && (s1_col_ff == in_col_ff);
         s1_pos_ff <= pos;
      end
      if (s1_valid_ff) begin
         for (int i = 0; i < NLINES; i++) begin
            last_vec_ff[i] <= vec[i];
         end
         for (int j = 0; j < SIDE; j++) begin
            cols_ff[0][j] <= vec[j];
         end
         for (int i = 1; i < SIDE; i++) begin
            cols_ff[i] <= cols_ff[i - 1];
         end
         s2_pos_ff <= s1_pos_ff;
      end
      if (s2_valid_ff) begin
         s3_med_ff <= med;
         s3_end_ff <= s2_pos_ff.frame_end;
      end
      if (s3_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* tb/tb_square_window_median_filter.sv */
// ---------------------------------------------------------------------------
// tb_square_window_median_filter
// Self-checking bench for the streaming clamp-to-edge median filter.
// Pixels are streamed through several frame geometries. A behavioral
// predictor keeps its own line store ring and computes each window median and
// frame peak. Results are matched in order against the predicted or tabled
// results, while rsp stalls and requests pause at random outside the quiet phase.
// ---------------------------------------------------------------------------
module tb_square_window_median_filter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W = 1024;
   localparam int MAX_H = 1024;
   localparam int MAX_R = 1;
   localparam int RING = 16;
   localparam logic [swmf_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 12;

   typedef struct {
      logic [swmf_pkg::FIELD_BITS-1:0] pixel;
      bit                              typed;
      swmf_pkg::result_type            want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [swmf_pkg::FIELD_BITS-1:0] req_pixel;
   logic rsp_valid;
   logic rsp_stall;
   logic [swmf_pkg::FIELD_BITS-1:0] rsp_filtered;
   logic rsp_frame_end;
   logic [swmf_pkg::FIELD_BITS-1:0] rsp_frame_peak;
   logic csr_valid;
   logic csr_ready;
   logic [swmf_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [swmf_pkg::CSR_DATA_BITS-1:0] csr_data;

   square_window_median_filter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_pixel(req_pixel),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_filtered(rsp_filtered),
      .rsp_frame_end(rsp_frame_end), .rsp_frame_peak(rsp_frame_peak),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // predictor state
   logic [swmf_pkg::FIELD_BITS-1:0] ring_rows [RING][MAX_W];
   logic [1:0]  radius_reg;
   logic [10:0] width_reg;
   logic [10:0] height_reg;
   int in_row, in_col, in_slot, out_row, out_col, out_base, fill_count;
   logic [swmf_pkg::FIELD_BITS-1:0] running_peak;

   swmf_pkg::result_type pending_medians[$];
   int mismatches, results_seen, requests_sent, frames_closed, settings_used;
   bit quiet;
   stim_row_type dir_tbl[10];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("square_window_median_filter test failed");
      $finish;
   end

   function automatic int clamp_int(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   task automatic restart_stream();
      in_row = 0; in_col = 0; in_slot = 0;
      out_row = 0; out_col = 0; out_base = 0;
      fill_count = 0; running_peak = '0;
   endtask

   task automatic compute_median(input logic [swmf_pkg::FIELD_BITS-1:0] pix, output bit got,
                                 output swmf_pkg::result_type res);
      int r, w, h, lag, n, row, col, slot, j;
      logic [swmf_pkg::FIELD_BITS-1:0] win [9];
      logic [swmf_pkg::FIELD_BITS-1:0] v;
      bit last;
      r = clamp_int(int'(radius_reg), 1, MAX_R);
      w = clamp_int(int'(width_reg), 1, MAX_W);
      h = clamp_int(int'(height_reg), 1, MAX_H);
      lag = r * w + r;
      got = 0;
      res = '0;
      if (in_col >= w) in_col = 0;
      ring_rows[in_slot][in_col] = pix;
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_slot = (in_slot + 1) % RING;
         in_row++;
         if (in_row >= h) in_row = 0;
      end
      if (fill_count < lag) begin
         fill_count++;
         return;
      end
      if (out_col >= w) out_col = 0;
      if (out_row >= h) out_row = 0;
      n = 0;
      for (int dy = -r; dy <= r; dy++) begin
         row = clamp_int(out_row + dy, 0, h - 1);
         slot = (out_base + row) % RING;
         for (int dx = -r; dx <= r; dx++) begin
            col = clamp_int(out_col + dx, 0, w - 1);
            if (n < 9) begin
               win[n] = ring_rows[slot][col];
               n++;
            end
         end
      end
      for (int i = 1; i < n; i++) begin
         v = win[i];
         j = i - 1;
         while (j >= 0 && win[j] > v) begin
            win[j + 1] = win[j];
            j--;
         end
         win[j + 1] = v;
      end
      res.filtered = win[n / 2];
      if (res.filtered > running_peak) running_peak = res.filtered;
      last = (out_row == h - 1) && (out_col == w - 1);
      res.frame_end = last;
      res.frame_peak = last ? running_peak : '0;
      got = 1;
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= h) begin
            out_row = 0;
            out_base = (out_base + h) % RING;
         end
      end
      if (last) running_peak = '0;
   endtask

   // called at a rising edge; returns at the edge where the request is taken or after a random idle gap
   task automatic send_pixel(input logic [swmf_pkg::FIELD_BITS-1:0] pix, input bit typed,
                             input swmf_pkg::result_type want);
      bit got;
      swmf_pkg::result_type res;
      req_valid <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      compute_median(pix, got, res);
      if (got) pending_medians.push_back(typed ? want : res);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [swmf_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [swmf_pkg::CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         swmf_pkg::CSR_RADIUS: radius_reg = val[1:0];
         swmf_pkg::CSR_WIDTH:  width_reg = val;
         swmf_pkg::CSR_HEIGHT: height_reg = val;
         default: return;
      endcase
      restart_stream();
   endtask

   task automatic set_geometry(input logic [1:0] r, input logic [10:0] w,
                               input logic [10:0] h);
      go_idle();
      write_csr(swmf_pkg::CSR_RADIUS, {9'd0, r});
      write_csr(swmf_pkg::CSR_WIDTH, w);
      write_csr(swmf_pkg::CSR_HEIGHT, h);
      settings_used++;
   endtask

   task automatic random_frames(input int count);
      swmf_pkg::result_type none;
      logic [swmf_pkg::FIELD_BITS-1:0] pix;
      none = '0;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 5))
            0: pix = '0;
            1: pix = '1;
            default: pix = 16'($urandom_range(0, 65535));
         endcase
         send_pixel(pix, 0, none);
      end
   endtask

   always @(posedge clock) begin
      swmf_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_medians.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result filtered=%h end=%b peak=%h",
                        rsp_filtered, rsp_frame_end, rsp_frame_peak);
         end else begin
            want = pending_medians.pop_front();
            if (want.frame_end) frames_closed++;
            if (rsp_filtered !== want.filtered || rsp_frame_end !== want.frame_end ||
                rsp_frame_peak !== want.frame_peak) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h/%b/%h got %h/%b/%h",
                           want.filtered, want.frame_end, want.frame_peak,
                           rsp_filtered, rsp_frame_end, rsp_frame_peak);
            end
         end
      end
   end

   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         repeat ($urandom_range(1, 20)) @(posedge clock);
         if (!quiet) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [swmf_pkg::FIELD_BITS-1:0] seq [10];
      swmf_pkg::result_type none;
      none = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel = '0;
      csr_valid = 1'b0;
      csr_index = swmf_pkg::CSR_RADIUS;
      csr_data = '0;
      quiet = 0;
      mismatches = 0; results_seen = 0; requests_sent = 0;
      frames_closed = 0; settings_used = 0;
      radius_reg = 2'd1; width_reg = 11'd1024; height_reg = 11'd1024;
      restart_stream();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single pixel frames: each result is the pixel two requests back
      seq = '{16'h0000, 16'hffff, 16'h0001, 16'h8000, 16'h7fff,
              16'haaaa, 16'h5555, 16'hffff, 16'h0000, 16'h1234};
      for (int i = 0; i < 10; i++) begin
         dir_tbl[i].pixel = seq[i];
         dir_tbl[i].typed = (i >= 2);
         dir_tbl[i].want.filtered = (i >= 2) ? seq[i - 2] : '0;
         dir_tbl[i].want.frame_end = 1'b1;
         dir_tbl[i].want.frame_peak = (i >= 2) ? seq[i - 2] : '0;
      end
      set_geometry(2'd0, 11'd0, 11'd0);
      foreach (dir_tbl[i]) send_pixel(dir_tbl[i].pixel, dir_tbl[i].typed, dir_tbl[i].want);

      // unknown register index leaves the stream running
      go_idle();
      write_csr(CSR_UNUSED, 11'h7ff);
      send_pixel(16'hc3c3, 0, none);

      set_geometry(2'd2, 11'd3, 11'd2);
      random_frames(14);
      set_geometry(2'd3, 11'd5, 11'd4);
      random_frames(30);
      go_idle();
      random_frames(10);
      set_geometry(2'd1, 11'd1, 11'd5);
      random_frames(16);
      set_geometry(2'd1, 11'd4, 11'd2047);
      random_frames(20);
      for (int k = 0; k < 4; k++) begin
         set_geometry(2'($urandom_range(0, 3)), 11'($urandom_range(1, 6)),
                      11'($urandom_range(1, 5)));
         random_frames($urandom_range(10, 15));
      end
      set_geometry(2'd1, 11'd4, 11'd3);
      quiet = 1;
      random_frames(20);
      req_valid <= 1'b0;

      fork
         begin
            while (pending_medians.size() != 0) @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
         begin
            repeat (20000) @(posedge clock);
            mismatches++;
            $display("timeout with %0d results outstanding", pending_medians.size());
         end
      join_any
      disable fork;

      $display("%0d pixels over %0d geometries, %0d medians checked, %0d frame ends",
               requests_sent, settings_used, results_seen, frames_closed);
      if (mismatches == 0 && pending_medians.size() == 0) begin
         $display("square_window_median_filter test passed");
      end else begin
         $display("square_window_median_filter test failed");
      end
      $finish;
   end
endmodule

/* sim.f */
sv/swmf_pkg.sv
sv/swmf_ram.sv
sv/square_window_median_filter.sv
tb/tb_square_window_median_filter.sv
